// File: design/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg
// Shared constants, types and tables for the grouped log-sum-exp block.
// ----------------------------------------------------------------------------
`default_nettype none

package gls_pkg;

  localparam int unsigned Groups   = 64;
  localparam int unsigned GroupW   = 6;
  localparam int unsigned ValueW   = 24;
  localparam int unsigned SumW     = 32;
  localparam int unsigned QueueLen = 2;

  localparam logic [31:0] OneQ16  = 32'd65536;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [15:0] Ln2Q16   = 16'd45426;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [GroupW-1:0]        group;
    logic                     first;
    logic                     last;
  } item_t;

  function automatic logic [16:0] pow2_frac(input logic [3:0] k);
    logic [16:0] r;
    begin
      case (k)
        4'd0:    r = 17'd65536;
        4'd1:    r = 17'd62757;
        4'd2:    r = 17'd60097;
        4'd3:    r = 17'd57549;
        4'd4:    r = 17'd55109;
        4'd5:    r = 17'd52773;
        4'd6:    r = 17'd50535;
        4'd7:    r = 17'd48393;
        4'd8:    r = 17'd46341;
        4'd9:    r = 17'd44376;
        4'd10:   r = 17'd42495;
        4'd11:   r = 17'd40693;
        4'd12:   r = 17'd38968;
        4'd13:   r = 17'd37316;
        4'd14:   r = 17'd35734;
        4'd15:   r = 17'd34219;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// File: design/gls_ram.sv
// ----------------------------------------------------------------------------
// gls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

// File: design/gls_front.sv
// ----------------------------------------------------------------------------
// gls_front
// Accepts input words, drops those for groups out of range and queues the
// rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_front
  import gls_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [ValueW-1:0] sample_value_i,
  input  wire logic [GroupW-1:0]        group_index_i,
  input  wire logic                     first_of_group_i,
  input  wire logic                     last_of_group_i,
  output logic                          q_valid_o,
  output item_t                         q_item_o,
  input  wire logic                     q_pop_i
);

  item_t       slot_q [QueueLen];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        accept, in_range, push;

  assign in_stall_o = (count_q == 2'(QueueLen));
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = ({1'b0, group_index_i} < (GroupW+1)'(Groups));
  assign push       = accept && in_range;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{value: sample_value_i, group: group_index_i,
                            first: first_of_group_i, last: last_of_group_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

`default_nettype wire

// File: design/gls_back.sv
// ----------------------------------------------------------------------------
// gls_back
// Sequencer that folds one queued word into its group's state and, on the
// last word of a group, works out ln(sum) + max.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_back
  import gls_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  input  wire item_t                    q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [GroupW-1:0]             result_group_o,
  output logic signed [ValueW-1:0]      lse_value_o,
  output logic                          saturated_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_E1   = 4'd2;
  localparam logic [3:0] S_E2   = 4'd3;
  localparam logic [3:0] S_E3   = 4'd4;
  localparam logic [3:0] S_E4   = 4'd5;
  localparam logic [3:0] S_E5   = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_LN0  = 4'd9;
  localparam logic [3:0] S_LN   = 4'd10;
  localparam logic [3:0] S_LM   = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]               state_q, state_d;
  item_t                    item_q;
  logic signed [ValueW-1:0] max_rd, nmax_q;
  logic [SumW-1:0]          sum_rd, nsum_q;
  logic                     grow_q;
  logic [23:0]              d_q;
  logic [24:0]              t_q;
  logic [11:0]              y_q;
  logic [16:0]              p_q, v_q, e_q;
  logic [31:0]              x_q;
  logic [15:0]              frac_q;
  logic [4:0]               pos_q;
  logic [3:0]               it_q;
  logic [20:0]              lnmag_q;
  logic                     lnneg_q;
  logic signed [ValueW-1:0] res_q;
  logic                     sat_q;
  logic                     wr_en;

  logic signed [ValueW:0]   diff;
  logic [40:0]              t_prod;
  logic [27:0]              y_prod;
  logic [23:0]              yy;
  logic [32:0]              v_prod;
  logic [48:0]              m_prod;
  logic [32:0]              m_sh, acc;
  logic [63:0]              sq;
  logic [32:0]              sq_sh;
  logic [4:0]               top;
  logic signed [21:0]       lg;
  logic [20:0]              lg_abs;
  logic [36:0]              ln_prod;
  logic signed [ValueW+1:0] res_full;

  gls_ram #(.WIDTH(ValueW), .DEPTH(Groups)) u_max_ram (
    .clk_i, .wr_en_i(wr_en), .wr_addr_i(item_q.group), .wr_data_i(nmax_q),
    .rd_addr_i(q_item_i.group), .rd_data_o(max_rd)
  );

  gls_ram #(.WIDTH(SumW), .DEPTH(Groups)) u_sum_ram (
    .clk_i, .wr_en_i(wr_en), .wr_addr_i(item_q.group), .wr_data_i(nsum_q),
    .rd_addr_i(q_item_i.group), .rd_data_o(sum_rd)
  );

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign wr_en   = (state_q == S_WR);

  always_comb begin
    diff    = {item_q.value[ValueW-1], item_q.value} - {max_rd[ValueW-1], max_rd};
    t_prod  = 41'(d_q) * 41'(Log2eQ16);
    y_prod  = 28'(t_q[11:0]) * 28'(Ln2Q16);
    yy      = 24'(y_q) * 24'(y_q);
    v_prod  = 33'(pow2_frac(t_q[15:12])) * 33'(p_q);
    m_prod  = 49'(nsum_q) * 49'(e_q);
    m_sh    = m_prod[48:16];
    acc     = 33'(nsum_q) + 33'(e_q);
    sq      = 64'(x_q) * 64'(x_q);
    sq_sh   = sq[63:31];
    top     = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (nsum_q[i]) top = 5'(i);
    end
    lg      = $signed({6'(pos_q) - 6'd16, frac_q});
    lg_abs  = lg[21] ? 21'(-lg) : lg[20:0];
    ln_prod = 37'(lg_abs) * 37'(Ln2Q16) + 37'd32768;
    res_full = (lnneg_q ? -$signed({5'd0, lnmag_q}) : $signed({5'd0, lnmag_q}))
               + 26'(nmax_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (q_valid_i) state_d = S_RD;
      S_RD:   state_d = item_q.first ? S_WR : S_E1;
      S_E1:   state_d = S_E2;
      S_E2:   state_d = S_E3;
      S_E3:   state_d = S_E4;
      S_E4:   state_d = S_E5;
      S_E5:   state_d = S_MUL;
      S_MUL:  state_d = S_WR;
      S_WR:   state_d = item_q.last ? S_LN0 : S_IDLE;
      S_LN0:  state_d = (nsum_q == '0) ? S_OUT : S_LN;
      S_LN:   if (it_q == 4'd15) state_d = S_LM;
      S_LM:   state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT:  if (!out_valid_o || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && (!out_valid_o || !out_stall_i)) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: item_q <= q_item_i;
      S_RD: begin
        if (item_q.first) begin
          nmax_q <= item_q.value;
          nsum_q <= OneQ16;
        end else begin
          grow_q <= !diff[ValueW] && (diff != '0);
          d_q    <= diff[ValueW] ? 24'(-diff) : diff[23:0];
          nmax_q <= (!diff[ValueW] && (diff != '0)) ? item_q.value : max_rd;
          nsum_q <= sum_rd;
        end
      end
      S_E1: t_q <= t_prod[40:16];
      S_E2: y_q <= y_prod[27:16];
      S_E3: p_q <= 17'(OneQ16) - 17'(y_q) + 17'(yy[23:17]);
      S_E4: v_q <= v_prod[32:16];
      S_E5: e_q <= (t_q[24:16] > 9'd16) ? 17'd0 : (v_q >> t_q[20:16]);
      S_MUL: begin
        if (grow_q) begin
          nsum_q <= (m_sh[32] || (33'(m_sh[31:0]) + 33'(OneQ16) > 33'hFFFFFFFF))
                    ? 32'hFFFFFFFF : m_sh[31:0] + OneQ16;
        end else begin
          nsum_q <= acc[32] ? 32'hFFFFFFFF : acc[31:0];
        end
      end
      S_LN0: begin
        pos_q  <= top;
        x_q    <= nsum_q << (5'd31 - top);
        frac_q <= '0;
        it_q   <= '0;
        res_q  <= {1'b1, {(ValueW-1){1'b0}}};
        sat_q  <= 1'b1;
      end
      S_LN: begin
        x_q    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        frac_q <= {frac_q[14:0], sq_sh[32]};
        it_q   <= it_q + 4'd1;
      end
      S_LM: begin
        lnmag_q <= ln_prod[36:16];
        lnneg_q <= lg[21];
      end
      S_FIN: begin
        if (res_full > 26'sd8388607) begin
          res_q <= 24'h7FFFFF;
          sat_q <= 1'b1;
        end else if (res_full < -26'sd8388608) begin
          res_q <= 24'h800000;
          sat_q <= 1'b1;
        end else begin
          res_q <= res_full[ValueW-1:0];
          sat_q <= 1'b0;
        end
      end
      S_OUT: begin
        if (!out_valid_o || !out_stall_i) begin
          result_group_o <= item_q.group;
          lse_value_o    <= res_q;
          saturated_o    <= sat_q;
        end
      end
      default: ;
    endcase
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == S_IDLE) && q_valid_i)
    else $error("queue popped outside idle");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(lse_value_o) && out_valid_o)
    else $error("stalled result changed");

  a_no_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && !item_q.last) |=> (state_q == S_IDLE))
    else $error("non-last word did not return to idle");

endmodule

`default_nettype wire

// File: design/grouped_online_log_sum_exp_top.sv
// ----------------------------------------------------------------------------
// grouped_online_log_sum_exp_top
// Streaming log-sum-exp over up to 64 interleaved groups of Q8.16 values.
// ----------------------------------------------------------------------------
// Words enter a two-deep queue and are folded one at a time by a sequencer
// that reads the group's maximum and sum from RAM, evaluates the exponential
// over five registered steps and writes the group back; the first word of a
// group skips the exponential. A last word then works out the logarithm,
// whose 16 squaring steps use one shared 32 by 32 multiplier. A group must
// be started before it is read.
`default_nettype none

module grouped_online_log_sum_exp_top
  import gls_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [ValueW-1:0] sample_value_i,
  input  wire logic [GroupW-1:0]        group_index_i,
  input  wire logic                     first_of_group_i,
  input  wire logic                     last_of_group_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [GroupW-1:0]             result_group_o,
  output logic signed [ValueW-1:0]      lse_value_o,
  output logic                          saturated_o
);

  logic  q_valid, q_pop;
  item_t q_item;

  gls_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_value_i,
    .group_index_i, .first_of_group_i, .last_of_group_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  gls_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .result_group_o, .lse_value_o, .saturated_o
  );

endmodule

`default_nettype wire
